/* sv/pwmt_pkg.sv */
// Shared constants, codes and types of the PWM timer with prescaler.
`default_nettype none
package pwmt_pkg;

    localparam int COUNT_BITS_DEF = 10;
    localparam int MAX_SHIFT_DEF  = 24;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int DATA_W      = 32;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic REG_CTRL  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam int CTRL_EN_BIT     = 0;
    localparam int CTRL_SEL_BIT    = 4;
    localparam int CTRL_SYNC_BIT   = 11;
    localparam int CTRL_FINE_BIT   = 15;
    localparam int CTRL_COARSE_LSB = 16;
    localparam int COARSE_BITS     = 4;
    localparam int CNT_PERIOD_LSB  = 16;

    typedef struct packed {
        logic tick;
        logic write;
        logic read;
        logic sel;
    } op_t;

endpackage
`default_nettype wire

/* sv/pwmt_regs.sv */
// Control and count registers, sync shadowing and live value apply.
`default_nettype none
module pwmt_regs #(
    parameter int COUNT_BITS = pwmt_pkg::COUNT_BITS_DEF,
    parameter int MAX_SHIFT  = pwmt_pkg::MAX_SHIFT_DEF,
    parameter int SHIFT_W    = $clog2(MAX_SHIFT + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire pwmt_pkg::op_t             op,
    input  wire logic [pwmt_pkg::DATA_W-1:0] wdata,
    output logic                           enable_next,
    output logic [COUNT_BITS-1:0]          live_period_next,
    output logic [COUNT_BITS-1:0]          live_high_next,
    output logic [SHIFT_W-1:0]             live_shift_next,
    output logic [pwmt_pkg::DATA_W-1:0]    read_data
);
    import pwmt_pkg::*;

    localparam logic [COARSE_BITS:0] MAX_SHIFT_V = (COARSE_BITS + 1)'(MAX_SHIFT);

    logic                   enable_reg, sel_bit_reg, sync_reg, fine_reg;
    logic [COARSE_BITS-1:0] coarse_reg;
    logic [COUNT_BITS-1:0]  period_reg, high_reg;
    logic [COUNT_BITS-1:0]  live_period_reg, live_high_reg;
    logic [SHIFT_W-1:0]     live_shift_reg;

    logic                   sel_bit_next, sync_next, fine_next;
    logic [COARSE_BITS-1:0] coarse_next;
    logic [COUNT_BITS-1:0]  period_next, high_next;
    logic [COARSE_BITS:0]   shift_sum;
    logic                   apply;

    always_comb
    begin
        enable_next  = enable_reg;
        sel_bit_next = sel_bit_reg;
        sync_next    = sync_reg;
        fine_next    = fine_reg;
        coarse_next  = coarse_reg;
        period_next  = period_reg;
        high_next    = high_reg;
        if (op.write && op.sel == REG_CTRL)
        begin
            enable_next  = wdata[CTRL_EN_BIT];
            sel_bit_next = wdata[CTRL_SEL_BIT];
            sync_next    = wdata[CTRL_SYNC_BIT];
            fine_next    = wdata[CTRL_FINE_BIT];
            coarse_next  = wdata[CTRL_COARSE_LSB +: COARSE_BITS];
        end
        if (op.write && op.sel == REG_COUNT)
        begin
            period_next = wdata[CNT_PERIOD_LSB +: COUNT_BITS];
            high_next   = wdata[COUNT_BITS-1:0];
        end
        apply     = op.write && !sync_next;
        shift_sum = {coarse_next, 1'b0} + (COARSE_BITS + 1)'(fine_next);
        live_period_next = live_period_reg;
        live_high_next   = live_high_reg;
        live_shift_next  = live_shift_reg;
        if (apply)
        begin
            live_period_next = period_next;
            live_high_next   = high_next;
            live_shift_next  = (shift_sum > MAX_SHIFT_V) ? SHIFT_W'(MAX_SHIFT)
                                                        : SHIFT_W'(shift_sum);
        end
    end

    always_comb
    begin
        read_data = '0;
        if (op.read)
        begin
            if (op.sel == REG_COUNT)
            begin
                read_data = (DATA_W'(period_reg) << CNT_PERIOD_LSB) | DATA_W'(high_reg);
            end
            else
            begin
                read_data[CTRL_EN_BIT]   = enable_reg;
                read_data[CTRL_SEL_BIT]  = sel_bit_reg;
                read_data[CTRL_SYNC_BIT] = sync_reg;
                read_data[CTRL_FINE_BIT] = fine_reg;
                read_data[CTRL_COARSE_LSB +: COARSE_BITS] = coarse_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            sel_bit_reg     <= 1'b0;
            sync_reg        <= 1'b0;
            fine_reg        <= 1'b0;
            coarse_reg      <= '0;
            period_reg      <= '0;
            high_reg        <= '0;
            live_period_reg <= '0;
            live_high_reg   <= '0;
            live_shift_reg  <= '0;
        end
        else if (advance)
        begin
            enable_reg      <= enable_next;
            sel_bit_reg     <= sel_bit_next;
            sync_reg        <= sync_next;
            fine_reg        <= fine_next;
            coarse_reg      <= coarse_next;
            period_reg      <= period_next;
            high_reg        <= high_next;
            live_period_reg <= live_period_next;
            live_high_reg   <= live_high_next;
            live_shift_reg  <= live_shift_next;
        end
    end

endmodule
`default_nettype wire

/* sv/pwmt_counter.sv */
// Prescale counter, period position counter and output level.
`default_nettype none
module pwmt_counter #(
    parameter int COUNT_BITS = pwmt_pkg::COUNT_BITS_DEF,
    parameter int MAX_SHIFT  = pwmt_pkg::MAX_SHIFT_DEF,
    parameter int SHIFT_W    = $clog2(MAX_SHIFT + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire pwmt_pkg::op_t         op,
    input  wire logic                  enable,
    input  wire logic [COUNT_BITS-1:0] live_period,
    input  wire logic [COUNT_BITS-1:0] live_high,
    input  wire logic [SHIFT_W-1:0]    live_shift,
    output logic                       pwm_next
);
    import pwmt_pkg::*;

    logic [MAX_SHIFT-1:0]  pre_reg, pre_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [MAX_SHIFT:0]    pre_inc;
    logic [COUNT_BITS:0]   pos_inc;

    always_comb
    begin
        pre_inc  = {1'b0, pre_reg} + (MAX_SHIFT + 1)'(1);
        pos_inc  = {1'b0, pos_reg} + (COUNT_BITS + 1)'(1);
        pre_next = pre_reg;
        pos_next = pos_reg;
        if (op.tick)
        begin
            if (!enable)
            begin
                pre_next = '0;
                pos_next = '0;
            end
            else if ((pre_inc >> live_shift) != '0)
            begin
                pre_next = '0;
                pos_next = (pos_inc >= {1'b0, live_period}) ? '0 : pos_inc[COUNT_BITS-1:0];
            end
            else
            begin
                pre_next = pre_inc[MAX_SHIFT-1:0];
            end
        end
        pwm_next = enable && (live_period != '0) && (live_high != '0)
                   && (pos_next < live_high);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= '0;
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pre_reg <= pre_next;
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

/* sv/pwm_timer_with_prescaler.sv */
// Top level of the PWM timer with power-of-two prescaler.
//
//   port group   dir   tdata                          tuser
//   s_axis       in    write_data[31:0]               func[1:0], reg_select[2]
//   m_axis       out   read_data[31:0], pwm_out[32]   -
//
// One word per cycle sustained while the output is not stalled; each word passes
// through the input register and its result through the output register.
// State and result are settled by one pass of logic behind the input register.
// Reset clears all timer state and both pipeline valids.
// A stalled output holds its word; the input still takes a word while the
// output is stalled only if its own register is empty.
`default_nettype none
module pwm_timer_with_prescaler #(
    parameter int COUNT_BITS = pwmt_pkg::COUNT_BITS_DEF,
    parameter int MAX_SHIFT  = pwmt_pkg::MAX_SHIFT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [pwmt_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // write_data
    input  wire logic [pwmt_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // func, reg_select
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [pwmt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // read_data, pwm_out, zeros
);
    import pwmt_pkg::*;

    localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);

    logic                  in_valid_reg;
    logic [1:0]            func_reg;
    logic                  sel_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     rdata_reg;
    logic                  pwm_reg;

    logic                  advance;
    op_t                   op;
    logic                  enable_next;
    logic [COUNT_BITS-1:0] live_period_next, live_high_next;
    logic [SHIFT_W-1:0]    live_shift_next;
    logic [DATA_W-1:0]     read_data;
    logic                  pwm_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - 1)'(0), pwm_reg, rdata_reg};

    always_comb
    begin
        op       = '0;
        op.sel   = sel_reg;
        unique case (func_reg)
            FUNC_TICK:  op.tick  = advance;
            FUNC_WRITE: op.write = advance;
            FUNC_READ:  op.read  = advance;
            default:    op.tick  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            func_reg  <= s_axis_tuser[1:0];
            sel_reg   <= s_axis_tuser[2];
            wdata_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= read_data;
            pwm_reg   <= pwm_next;
        end
    end

    pwmt_regs #(
        .COUNT_BITS (COUNT_BITS),
        .MAX_SHIFT  (MAX_SHIFT),
        .SHIFT_W    (SHIFT_W)
    ) u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .op               (op),
        .wdata            (wdata_reg),
        .enable_next      (enable_next),
        .live_period_next (live_period_next),
        .live_high_next   (live_high_next),
        .live_shift_next  (live_shift_next),
        .read_data        (read_data)
    );

    pwmt_counter #(
        .COUNT_BITS (COUNT_BITS),
        .MAX_SHIFT  (MAX_SHIFT),
        .SHIFT_W    (SHIFT_W)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .op          (op),
        .enable      (enable_next),
        .live_period (live_period_next),
        .live_high   (live_high_next),
        .live_shift  (live_shift_next),
        .pwm_next    (pwm_next)
    );

endmodule
`default_nettype wire

/* sv/pwmt_checker.sv */
// Port-level checks of the PWM timer, bound to the top level.
`default_nettype none
module pwmt_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [pwmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pwmt_pkg::*;

    // padding above pwm_out is always zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:DATA_W+1] == '0)
        else $error("output padding not zero");

    // input only backs up when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // a word taken while the output is empty comes out through the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
        else $error("result missing after accepted word");

endmodule

bind pwm_timer_with_prescaler pwmt_checker u_pwmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
